/* hdl/hlf_pkg.sv */
// ----------------------------------------------------------------------------
// hlf_pkg
// shared constants and types for the hashed lamp brightness pipeline
// ----------------------------------------------------------------------------
package hlf_pkg;

  // default size of the sine table used by the pulse mood
  localparam int unsigned SINE_ENTRIES_DEF = 256;

  // register stages between input and the output register
  localparam int unsigned NUM_STAGES = 12;

  localparam int unsigned FRAC_W = 24;
  localparam int unsigned LVL_W  = 17;

  // hash mixer multipliers
  localparam logic [31:0] MIX_K_SEED = 32'h9E3779B1;
  localparam logic [31:0] MIX_K_STEP = 32'h85EBCA77;
  localparam logic [31:0] MIX_K_A    = 32'h2C1B3C6D;
  localparam logic [31:0] MIX_K_B    = 32'h297A2D39;

  // reciprocals for division by constants (shift given beside each)
  localparam logic [31:0] RCP_3  = 32'hAAAAAAAB;  // >> 33
  localparam logic [31:0] RCP_5  = 32'hCCCCCCCD;  // >> 34
  localparam logic [31:0] RCP_9  = 32'h38E38E39;  // >> 33
  localparam logic [31:0] RCP_51 = 32'hA0A0A0A1;  // >> 37

  // mood codes
  localparam logic [2:0] MOOD_STEADY  = 3'd0;
  localparam logic [2:0] MOOD_FLICKER = 3'd1;
  localparam logic [2:0] MOOD_FAILING = 3'd2;
  localparam logic [2:0] MOOD_DEAD    = 3'd3;
  localparam logic [2:0] MOOD_PULSE   = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_MOOD    = 2'd0;
  localparam logic [1:0] CFG_SEED    = 2'd1;
  localparam logic [1:0] CFG_BATTERY = 2'd2;

  // levels
  localparam logic [LVL_W-1:0] LVL_FULL    = 17'd65536;
  localparam logic [LVL_W-1:0] LVL_VISIBLE = 17'd655;

  // hash fraction thresholds
  localparam logic [FRAC_W-1:0] FLK_DIP_TH    = 24'd838861;
  localparam logic [FRAC_W-1:0] FAIL_DARK_TH  = 24'd9227469;
  localparam logic [FRAC_W-1:0] FAIL_QUIET_TH = 24'd7549747;

  // seed offsets of the hash lanes
  localparam logic [31:0] SEED_OFS_FLK_LO  = 32'd1;
  localparam logic [31:0] SEED_OFS_FLK_HI  = 32'd2;
  localparam logic [31:0] SEED_OFS_QUIET   = 32'd3;
  localparam logic [31:0] SEED_OFS_ON      = 32'd4;
  localparam logic [31:0] SEED_OFS_DARK    = 32'd7;

  // time quotients handed from the divider front end
  typedef struct packed {
    logic [29:0] q6;    // time / 6
    logic [29:0] q5;    // time / 5
    logic [23:0] slot;  // time / 288
  } tsteps_t;

endpackage

/* hdl/hashed_light_flicker_level.sv */
// ----------------------------------------------------------------------------
// hashed_light_flicker_level
// per-lamp brightness from time and power, hashed flicker / failing / pulse
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  in_      | request   | in_tvalid / in_tready  | time_ticks, circuit_powered
//  out_     | result    | out_tvalid / out_tready| brightness, visible
//  cfg_     | write     | cfg_wen                | mood, lamp_seed, battery_backed
//
//  one request per cycle while in_tready is high; a result passes through
//  the 12 pipeline stages set by the hash and sine multiplier chains, then
//  the output register
//  rst_n is synchronous; it clears the stage valids, the output side and
//  the configuration registers (mood steady, seed 17, not battery backed)
//  a stalled output parks at most one result in a skid entry; in_tready
//  drops only while that entry is full, and the whole pipe holds with it
// ----------------------------------------------------------------------------
module hashed_light_flicker_level import hlf_pkg::*; #(
  parameter int unsigned SINE_ENTRIES = SINE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // [31:0] time_ticks, [32] circuit_powered, zero fill
  // result
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [16:0] brightness, [17] visible, zero fill
  // configuration
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  // configuration registers
  logic [2:0]  mood_r;
  logic [31:0] seed_r;
  logic        battery_r;

  // pipeline control
  logic                  en;
  logic [NUM_STAGES-1:0] v_r;

  // divider front end
  tsteps_t             steps;
  logic [8:0]          r288;
  logic [FRAC_W-1:0]   frac;

  // hash lanes
  logic [31:0]       lane_seed [4];
  logic [31:0]       lane_step [4];
  logic [FRAC_W-1:0] h [4];

  // power flag carried to stage 5
  logic              pwr_r [4];

  // stage 5 level for the non-pulse moods
  logic [38:0]       p_flk_lo;
  logic [36:0]       p_flk_hi;
  logic [38:0]       p_fail_on;
  logic [LVL_W-1:0]  flk_lo;
  logic [LVL_W-1:0]  flk_hi;
  logic [LVL_W-1:0]  fail_on;
  logic [32:0]       burst;
  logic [32:0]       into;
  logic              fail_dark;
  logic [LVL_W-1:0]  alt;
  logic              lit;
  logic [LVL_W-1:0]  alt_nxt;
  logic              pulse_nxt;
  logic [LVL_W-1:0]  alt_r [8];
  logic              pulse_r [8];

  // pulse level
  logic [LVL_W-1:0]  wave_lvl;

  // output side
  logic [LVL_W-1:0]  fin_lvl;
  logic              fin_vis;
  logic              arrive;
  logic              take;
  logic              out_v_r;
  logic              skid_v_r;
  logic              out_v_nxt;
  logic              skid_v_nxt;
  logic              load_out;
  logic              load_skid;
  logic              out_from_skid;
  logic [LVL_W-1:0]  out_lvl_r;
  logic              out_vis_r;
  logic [LVL_W-1:0]  skid_lvl_r;
  logic              skid_vis_r;

  // --------------------------------------------------------------------------
  // configuration writes, unknown indexes fall through
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mood_r    <= MOOD_STEADY;
      seed_r    <= 32'd17;
      battery_r <= 1'b0;
    end else if (cfg_wen) begin
      case (cfg_addr)
        CFG_MOOD:    mood_r    <= cfg_wdata[2:0];
        CFG_SEED:    seed_r    <= cfg_wdata;
        CFG_BATTERY: battery_r <= cfg_wdata[0];
        default:     ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // the pipe moves as long as the skid entry is free
  // --------------------------------------------------------------------------
  assign en        = !skid_v_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NUM_STAGES-2:0], in_tvalid};
    end
  end

  // stages 1 to 4: quotients, remainders, pulse phase fraction
  hlf_tdiv u_tdiv (
    .clk   (clk),
    .en    (en),
    .t_in  (in_tdata[31:0]),
    .steps (steps),
    .r288  (r288),
    .frac  (frac)
  );

  // lane roles per mood
  //   lane 0: flicker dip pick / failing burst length / pulse phase offset
  //   lane 1: flicker dip depth / failing dark slot
  //   lane 2: flicker bright jitter / failing quiet step
  //   lane 3: failing burst level
  always_comb begin
    lane_seed[0] = seed_r;
    lane_seed[3] = seed_r + SEED_OFS_ON;
    lane_step[3] = 32'(steps.q5);
    case (mood_r)
      MOOD_FLICKER: begin
        lane_step[0] = 32'(steps.q6);
        lane_seed[1] = seed_r + SEED_OFS_FLK_LO;
        lane_step[1] = 32'(steps.q6);
        lane_seed[2] = seed_r + SEED_OFS_FLK_HI;
        lane_step[2] = 32'(steps.q6);
      end
      MOOD_FAILING: begin
        lane_step[0] = 32'(steps.slot);
        lane_seed[1] = seed_r + SEED_OFS_DARK;
        lane_step[1] = 32'(steps.slot);
        lane_seed[2] = seed_r + SEED_OFS_QUIET;
        lane_step[2] = 32'(steps.q5);
      end
      default: begin
        lane_step[0] = 32'd0;
        lane_seed[1] = seed_r + SEED_OFS_FLK_LO;
        lane_step[1] = 32'(steps.q6);
        lane_seed[2] = seed_r + SEED_OFS_FLK_HI;
        lane_step[2] = 32'(steps.q6);
      end
    endcase
  end

  // stages 2 to 4: hash lanes
  for (genvar g = 0; g < 4; g++) begin : g_lane
    hlf_mix u_mix (
      .clk  (clk),
      .en   (en),
      .seed (lane_seed[g]),
      .step (lane_step[g]),
      .h    (h[g])
    );
  end

  // power flag travels alongside until the level decision
  always_ff @(posedge clk) begin
    if (en) begin
      pwr_r[0] <= in_tdata[32];
      pwr_r[1] <= pwr_r[0];
      pwr_r[2] <= pwr_r[1];
      pwr_r[3] <= pwr_r[2];
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: flicker and failing levels, power gate
  // --------------------------------------------------------------------------
  assign p_flk_lo  = 39'(h[1]) * 39'd26214;
  assign p_flk_hi  = 37'(h[2]) * 37'd5243;
  assign p_fail_on = 39'(h[3]) * 39'd26214;
  assign flk_lo    = 17'd9830  + 17'(p_flk_lo[24 +: 15]);
  assign flk_hi    = 17'd60293 + 17'(p_flk_hi[24 +: 13]);
  assign fail_on   = 17'd39322 + 17'(p_fail_on[24 +: 15]);

  // burst lasts 0.35 s plus up to 0.9 s of the slot, in Q24 ticks
  assign burst     = (33'd42 << 24) + 33'(h[0]) * 33'd108;
  assign into      = {r288, 24'b0};
  assign fail_dark = (h[1] < FAIL_DARK_TH) || (into > burst) || (h[2] < FAIL_QUIET_TH);

  always_comb begin
    case (mood_r)
      MOOD_FLICKER: alt = (h[0] < FLK_DIP_TH) ? flk_lo : flk_hi;
      MOOD_FAILING: alt = fail_dark ? '0 : fail_on;
      MOOD_DEAD:    alt = '0;
      MOOD_PULSE:   alt = '0;
      default:      alt = LVL_FULL;   // steady and the unused codes
    endcase
  end

  assign lit       = pwr_r[3] || battery_r;
  assign alt_nxt   = lit ? alt : '0;
  assign pulse_nxt = lit && (mood_r == MOOD_PULSE);

  // stages 5 to 12: hold the level beside the pulse pipe
  always_ff @(posedge clk) begin
    if (en) begin
      alt_r[0]   <= alt_nxt;
      pulse_r[0] <= pulse_nxt;
      for (int i = 1; i < 8; i++) begin
        alt_r[i]   <= alt_r[i-1];
        pulse_r[i] <= pulse_r[i-1];
      end
    end
  end

  // stages 5 to 12: pulse swell
  hlf_wave #(
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_wave (
    .clk  (clk),
    .en   (en),
    .frac (frac),
    .h0   (h[0]),
    .lvl  (wave_lvl)
  );

  // --------------------------------------------------------------------------
  // output register with one skid entry
  // --------------------------------------------------------------------------
  assign fin_lvl = pulse_r[7] ? wave_lvl : alt_r[7];
  assign fin_vis = fin_lvl > LVL_VISIBLE;

  assign arrive = en && v_r[NUM_STAGES-1];
  assign take   = out_v_r && out_tready;

  always_comb begin
    out_v_nxt     = out_v_r;
    skid_v_nxt    = skid_v_r;
    load_out      = 1'b0;
    load_skid     = 1'b0;
    out_from_skid = 1'b0;
    if (skid_v_r) begin
      if (take) begin
        load_out      = 1'b1;
        out_from_skid = 1'b1;
        skid_v_nxt    = 1'b0;
      end
    end else if (arrive) begin
      if (!out_v_r || take) begin
        load_out  = 1'b1;
        out_v_nxt = 1'b1;
      end else begin
        load_skid  = 1'b1;
        skid_v_nxt = 1'b1;
      end
    end else if (take) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_lvl_r <= out_from_skid ? skid_lvl_r : fin_lvl;
      out_vis_r <= out_from_skid ? skid_vis_r : fin_vis;
    end
    if (load_skid) begin
      skid_lvl_r <= fin_lvl;
      skid_vis_r <= fin_vis;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'b0, out_vis_r, out_lvl_r};

endmodule

/* hdl/hlf_tdiv.sv */
// ----------------------------------------------------------------------------
// hlf_tdiv
// time quotients and remainders by reciprocal multiplication, stages 1 to 4
// ----------------------------------------------------------------------------
module hlf_tdiv import hlf_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [31:0]         t_in,
  output tsteps_t             steps,   // stage 1
  output logic [8:0]          r288,    // stage 4, time mod 288
  output logic [FRAC_W-1:0]   frac     // stage 4, (time mod 204) / 204 in Q24
);

  logic [62:0] p6;
  logic [63:0] p5;
  logic [58:0] p9;
  logic [61:0] p51;

  logic [31:0] t_r;
  logic [29:0] q6_r;
  logic [29:0] q5_r;
  logic [23:0] slot_r;
  logic [24:0] q51_r;

  logic [31:0] m288;
  logic [31:0] d288;
  logic [29:0] m51;
  logic [29:0] d51;
  logic [8:0]  r288_nxt;
  logic [7:0]  r204_nxt;

  logic [8:0]  r288_s2_r;
  logic [7:0]  r204_s2_r;
  logic [8:0]  r288_s3_r;
  logic [7:0]  r204_s3_r;
  logic [39:0] pf;
  logic [8:0]  r288_s4_r;
  logic [FRAC_W-1:0] frac_r;

  // stage 1: quotients
  assign p6  = 63'(t_in[31:1]) * 63'(RCP_3);
  assign p5  = 64'(t_in) * 64'(RCP_5);
  assign p9  = 59'(t_in[31:5]) * 59'(RCP_9);
  assign p51 = 62'(t_in[31:2]) * 62'(RCP_51);

  always_ff @(posedge clk) begin
    if (en) begin
      t_r    <= t_in;
      q6_r   <= p6[33 +: 30];
      q5_r   <= p5[34 +: 30];
      slot_r <= p9[33 +: 24];
      q51_r  <= p51[37 +: 25];
    end
  end

  assign steps.q6   = q6_r;
  assign steps.q5   = q5_r;
  assign steps.slot = slot_r;

  // stage 2: remainders, only the low bits survive
  assign m288     = {slot_r, 8'b0} + 32'({slot_r, 5'b0});
  assign d288     = t_r - m288;
  assign r288_nxt = d288[8:0];
  assign m51      = 30'(q51_r) * 30'd51;
  assign d51      = t_r[31:2] - m51;
  assign r204_nxt = {d51[5:0], t_r[1:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      r288_s2_r <= r288_nxt;
      r204_s2_r <= r204_nxt;
      r288_s3_r <= r288_s2_r;
      r204_s3_r <= r204_s2_r;
    end
  end

  // stage 4: r * 2^24 / 204 = r * 2^22 / 51
  assign pf = 40'(r204_s3_r) * 40'(RCP_51);

  always_ff @(posedge clk) begin
    if (en) begin
      r288_s4_r <= r288_s3_r;
      frac_r    <= pf[15 +: FRAC_W];
    end
  end

  assign r288 = r288_s4_r;
  assign frac = frac_r;

endmodule

/* hdl/hlf_mix.sv */
// ----------------------------------------------------------------------------
// hlf_mix
// three-stage multiply / xorshift hash lane, low 24 bits out
// ----------------------------------------------------------------------------
module hlf_mix import hlf_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [31:0]       seed,
  input  logic [31:0]       step,
  output logic [FRAC_W-1:0] h
);

  logic [31:0] a_nxt;
  logic [31:0] b_nxt;
  logic [31:0] c_nxt;
  logic [31:0] a_r;
  logic [31:0] b_r;
  logic [31:0] c_r;
  logic [31:0] fold;

  assign a_nxt = (seed * MIX_K_SEED) ^ (step * MIX_K_STEP);
  assign b_nxt = (a_r ^ (a_r >> 15)) * MIX_K_A;
  assign c_nxt = (b_r ^ (b_r >> 12)) * MIX_K_B;

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      c_r <= c_nxt;
    end
  end

  assign fold = c_r ^ (c_r >> 15);
  assign h    = fold[FRAC_W-1:0];

endmodule

/* hdl/hlf_wave.sv */
// ----------------------------------------------------------------------------
// hlf_wave
// pulse level: table index, quarter-wave sine polynomial, squared swell
// ----------------------------------------------------------------------------
module hlf_wave import hlf_pkg::*; #(
  parameter int unsigned SINE_ENTRIES = SINE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              en,
  input  logic [FRAC_W-1:0] frac,   // stage 4
  input  logic [FRAC_W-1:0] h0,     // stage 4
  output logic [LVL_W-1:0]  lvl     // stage 12
);

  localparam int unsigned IDX_W = $clog2(SINE_ENTRIES);
  localparam int unsigned NW    = $clog2(SINE_ENTRIES + 1);
  localparam int unsigned REC_W = 45 - IDX_W;
  localparam int unsigned PN_W  = FRAC_W + NW;
  localparam int unsigned UP_W  = IDX_W + REC_W;
  localparam logic [NW-1:0]    N_V   = NW'(SINE_ENTRIES);
  // exact floor(idx * 2^18 / entries) as (idx * RECIP) >> 26
  localparam logic [REC_W-1:0] RECIP = REC_W'(((64'd1 << 44) + 64'(SINE_ENTRIES) - 64'd1)
                                              / 64'(SINE_ENTRIES));

  logic [FRAC_W-1:0] phase;
  logic [PN_W-1:0]   pn;
  logic [IDX_W-1:0]  idx_r;
  logic [UP_W-1:0]   up;
  logic [17:0]       u_r;
  logic [16:0]       x_nxt;
  logic [33:0]       xx;
  logic [16:0]       x_s7_r;
  logic [16:0]       x2_s7_r;
  logic              neg_s7_r;
  logic [29:0]       p1;
  logic [15:0]       t2_nxt;
  logic [15:0]       t2_r;
  logic [16:0]       x_s8_r;
  logic [16:0]       x2_s8_r;
  logic              neg_s8_r;
  logic [32:0]       p3;
  logic [16:0]       t4_nxt;
  logic [16:0]       t4_r;
  logic [16:0]       x_s9_r;
  logic              neg_s9_r;
  logic [33:0]       p5;
  logic [16:0]       t5;
  logic [16:0]       s_nxt;
  logic [16:0]       s_r;
  logic              neg_s10_r;
  logic [17:0]       wsum;
  logic [16:0]       w;
  logic [33:0]       ww;
  logic [16:0]       w2_r;
  logic [32:0]       pl;
  logic [LVL_W-1:0]  lvl_r;

  // stage 5: phase and table index
  assign phase = frac + h0;
  assign pn    = PN_W'(phase) * PN_W'(N_V);

  // stage 6: position in quarter turns, Q16
  assign up = UP_W'(idx_r) * UP_W'(RECIP);

  // stage 7: fold into the first quadrant, x^2
  assign x_nxt = u_r[16] ? (17'd65536 - {1'b0, u_r[15:0]}) : {1'b0, u_r[15:0]};
  assign xx    = 34'(x_nxt) * 34'(x_nxt);

  // stage 8 to 10: odd polynomial in x
  assign p1     = 30'(x2_s7_r) * 30'd5210;
  assign t2_nxt = 16'd42334 - 16'(p1[16 +: 13]);
  assign p3     = 33'(t2_r) * 33'(x2_s8_r);
  assign t4_nxt = 17'd102944 - p3[16 +: 17];
  assign p5     = 34'(t4_r) * 34'(x_s9_r);
  assign t5     = p5[16 +: 17];
  assign s_nxt  = (t5 > LVL_FULL) ? LVL_FULL : t5;

  // stage 11: half-biased wave squared
  assign wsum = neg_s10_r ? (18'd65536 - 18'(s_r)) : (18'd65536 + 18'(s_r));
  assign w    = wsum[17:1];
  assign ww   = 34'(w) * 34'(w);

  // stage 12: 0.3 + 0.7 * w^2
  assign pl = 33'(w2_r) * 33'd45875;

  always_ff @(posedge clk) begin
    if (en) begin
      idx_r     <= pn[FRAC_W +: IDX_W];
      u_r       <= up[26 +: 18];
      x_s7_r    <= x_nxt;
      x2_s7_r   <= xx[16 +: 17];
      neg_s7_r  <= u_r[17];
      t2_r      <= t2_nxt;
      x_s8_r    <= x_s7_r;
      x2_s8_r   <= x2_s7_r;
      neg_s8_r  <= neg_s7_r;
      t4_r      <= t4_nxt;
      x_s9_r    <= x_s8_r;
      neg_s9_r  <= neg_s8_r;
      s_r       <= s_nxt;
      neg_s10_r <= neg_s9_r;
      w2_r      <= ww[16 +: 17];
      lvl_r     <= 17'd19661 + 17'(pl[16 +: 16]);
    end
  end

  assign lvl = lvl_r;

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the hashed lamp brightness block: a directed table
// of settings and requests (reset values, field extremes, every mood, power
// and seed wrap cases) followed by random phases whose request times are
// aimed at flicker dips and lit failing bursts; every result is compared
// against its row's typed value or a bit-exact lamp model under random stalls
// ----------------------------------------------------------------------------
module tb_top;
  import hlf_pkg::*;

  // mood codes beyond the named five fall back to full level
  localparam logic [2:0] MOOD_SPARE5 = 3'd5;
  localparam logic [2:0] MOOD_SPARE6 = 3'd6;
  localparam logic [2:0] MOOD_SPARE7 = 3'd7;
  // register index with no register behind it
  localparam logic [1:0] CFG_UNUSED  = 2'd3;

  localparam int unsigned PULSE_TICKS     = 204;
  localparam int unsigned FLK_STEP_TICKS  = 6;
  localparam int unsigned FAIL_SLOT_TICKS = 288;
  localparam int unsigned FAIL_STEP_TICKS = 5;
  localparam int unsigned FLK_STEADY_BASE = 60293;

  // last slot / flicker step whose ticks all fit in 32 bits
  localparam int unsigned SLOT_MAX = 14913079;
  localparam int unsigned FSTEP_MAX = 715827881;

  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_ITEMS = 46;
  localparam int unsigned CALM_PHASES = 2;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct packed {
    logic [16:0] level;
    logic        lit;
  } lamp_out_t;

  typedef struct packed {
    logic [2:0]  mood;
    logic [31:0] seed;
    logic        batt;
    logic [31:0] t_ticks;
    logic        pwr;
    logic        typed;   // expected value given in the row itself
    logic [16:0] level;
    logic        lit;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_wen = 1'b0;
  logic [1:0]  cfg_addr = CFG_MOOD;
  logic [31:0] cfg_wdata = '0;

  // shadow of the block's registers, reset values
  logic [2:0]  cur_mood = MOOD_STEADY;
  logic [31:0] cur_seed = 32'd17;
  logic        cur_batt = 1'b0;

  lamp_out_t   level_q[$];
  plan_row_t   plan_q[$];

  logic        idle_on = 1'b1;
  int unsigned gap_pct = 20;
  int unsigned quiet_cycles = 0;
  int unsigned n_req = 0;
  int unsigned n_checked = 0;
  int unsigned n_settings = 0;
  int unsigned n_dips = 0;
  int unsigned n_lit_bursts = 0;
  int unsigned n_errors = 0;

  hashed_light_flicker_level uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [31:0] time_ticks, [32] circuit_powered
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [16:0] brightness, [17] visible
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // lamp model
  // ---------------------------------------------------------------------------

  // multiply / xorshift mixer of (seed, step), low 24 bits as a fraction
  function automatic logic [23:0] hash_frac(input logic [31:0] seed, input logic [31:0] tstep);
    logic [31:0] h;
    h = (seed * MIX_K_SEED) ^ (tstep * MIX_K_STEP);
    h = h ^ (h >> 15);
    h = h * MIX_K_A;
    h = h ^ (h >> 12);
    h = h * MIX_K_B;
    h = h ^ (h >> 15);
    return h[23:0];
  endfunction

  // sin(pi/2 * x), x and result in q16, odd polynomial, clamped to [0, 1]
  function automatic longint quarter_wave(input longint x);
    longint x2;
    longint acc;
    x2  = (x * x) >>> 16;
    acc = (5210 * x2) >>> 16;
    acc = 42334 - acc;
    acc = (acc * x2) >>> 16;
    acc = 102944 - acc;
    acc = (acc * x) >>> 16;
    if (acc > 65536) acc = 65536;
    if (acc < 0) acc = 0;
    return acc;
  endfunction

  // signed q16 sine of idx / SINE_ENTRIES turn, built from quarter waves
  function automatic longint sine_q16(input int unsigned idx);
    longint unsigned u;
    int unsigned     quad;
    longint          f;
    longint          x;
    longint          s;
    u    = (64'(idx) << 18) / SINE_ENTRIES_DEF;
    quad = int'((u >> 16) & 64'd3);
    f    = longint'(u & 64'hFFFF);
    x    = quad[0] ? (65536 - f) : f;
    s    = quarter_wave(x);
    return quad[1] ? -s : s;
  endfunction

  function automatic logic [16:0] lamp_level(input logic [2:0] m, input logic [31:0] s,
                                             input logic b, input logic [31:0] t,
                                             input logic p);
    int unsigned lvl;
    logic [63:0] frac;
    logic [63:0] ph;
    logic [63:0] burst;
    int unsigned idx;
    longint      w;
    longint      w2;
    logic [31:0] tstep;
    logic [31:0] slot;
    logic [31:0] into;
    // dark circuit, unless the lamp has its own battery
    if (!p && !b) return '0;
    case (m)
      MOOD_DEAD: begin
        lvl = 0;
      end
      MOOD_PULSE: begin
        // squared sine swell, phase shifted per lamp
        frac = (64'(t % PULSE_TICKS) << 24) / PULSE_TICKS;
        ph   = (frac + 64'(hash_frac(s, 32'd0))) & 64'hFFFFFF;
        idx  = int'((ph * SINE_ENTRIES_DEF) >> 24);
        w    = (65536 + sine_q16(idx)) / 2;
        w2   = (w * w) >>> 16;
        lvl  = int'(19661 + ((45875 * w2) >>> 16));
      end
      MOOD_FLICKER: begin
        tstep = t / FLK_STEP_TICKS;
        if (hash_frac(s, tstep) < FLK_DIP_TH)
          lvl = 9830 + ((64'd26214 * hash_frac(s + SEED_OFS_FLK_LO, tstep)) >> 24);
        else
          lvl = 60293 + ((64'd5243 * hash_frac(s + SEED_OFS_FLK_HI, tstep)) >> 24);
      end
      MOOD_FAILING: begin
        slot  = t / FAIL_SLOT_TICKS;
        into  = t % FAIL_SLOT_TICKS;
        burst = (64'd42 << 24) + 64'd108 * hash_frac(s, slot);
        if (hash_frac(s + SEED_OFS_DARK, slot) < FAIL_DARK_TH || (64'(into) << 24) > burst) begin
          lvl = 0;
        end else begin
          // inside a burst: stutter on 5-tick steps
          tstep = t / FAIL_STEP_TICKS;
          if (hash_frac(s + SEED_OFS_QUIET, tstep) < FAIL_QUIET_TH)
            lvl = 0;
          else
            lvl = 39322 + ((64'd26214 * hash_frac(s + SEED_OFS_ON, tstep)) >> 24);
        end
      end
      default: begin
        // steady and the spare codes
        lvl = LVL_FULL;
      end
    endcase
    if (lvl > LVL_FULL) lvl = LVL_FULL;
    return lvl[16:0];
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_row(input logic [2:0] m, input logic [31:0] s, input logic b,
                         input logic [31:0] t, input logic p, input logic typed,
                         input logic [16:0] lvl, input logic lit);
    plan_row_t row;
    row    = '{m, s, b, t, p, typed, lvl, lit};
    plan_q = {plan_q, row};
  endtask

  // directed part: typed values only where they are obvious
  task automatic build_plan();
    // reset values: steady, seed 17, mains powered
    add_row(MOOD_STEADY,  32'd17,       1'b0, 32'h0,        1'b1, 1'b1, LVL_FULL, 1'b1);
    add_row(MOOD_STEADY,  32'd17,       1'b0, 32'hFFFFFFFF, 1'b1, 1'b1, LVL_FULL, 1'b1);
    // unpowered mains lamp goes dark
    add_row(MOOD_STEADY,  32'd17,       1'b0, 32'd5,        1'b0, 1'b1, '0,       1'b0);
    add_row(MOOD_DEAD,    32'd17,       1'b0, 32'd1000,     1'b1, 1'b1, '0,       1'b0);
    add_row(MOOD_DEAD,    32'd17,       1'b1, 32'h7FFFFFFF, 1'b0, 1'b1, '0,       1'b0);
    // emergency lamp ignores circuit power
    add_row(MOOD_STEADY,  32'd17,       1'b1, 32'h80000000, 1'b0, 1'b1, LVL_FULL, 1'b1);
    // spare mood codes act as steady
    add_row(MOOD_SPARE5,  32'd17,       1'b0, 32'h12345678, 1'b1, 1'b1, LVL_FULL, 1'b1);
    add_row(MOOD_SPARE6,  32'd17,       1'b0, 32'h0,        1'b1, 1'b1, LVL_FULL, 1'b1);
    add_row(MOOD_SPARE7,  32'd17,       1'b0, 32'hFFFFFFFF, 1'b1, 1'b1, LVL_FULL, 1'b1);
    // pulse: period edges and largest time
    add_row(MOOD_PULSE,   32'd17,       1'b0, 32'd0,        1'b1, 1'b0, '0,       1'b0);
    add_row(MOOD_PULSE,   32'd17,       1'b0, 32'd203,      1'b1, 1'b0, '0,       1'b0);
    add_row(MOOD_PULSE,   32'd17,       1'b0, 32'hFFFFFFFF, 1'b1, 1'b0, '0,       1'b0);
    add_row(MOOD_PULSE,   32'hFFFFFFFF, 1'b0, 32'd102,      1'b1, 1'b0, '0,       1'b0);
    add_row(MOOD_PULSE,   32'd0,        1'b1, 32'd51,       1'b0, 1'b0, '0,       1'b0);
    // flicker: seed + 1 and seed + 2 wrap
    add_row(MOOD_FLICKER, 32'hFFFFFFFF, 1'b0, 32'd0,        1'b1, 1'b0, '0,       1'b0);
    add_row(MOOD_FLICKER, 32'hFFFFFFFF, 1'b0, 32'hFFFFFFFF, 1'b1, 1'b0, '0,       1'b0);
    add_row(MOOD_FLICKER, 32'd0,        1'b0, 32'd6,        1'b1, 1'b0, '0,       1'b0);
    add_row(MOOD_FLICKER, 32'd0,        1'b0, 32'd5,        1'b1, 1'b0, '0,       1'b0);
    // failing: seed + 4 and seed + 7 wrap, slot edges
    add_row(MOOD_FAILING, 32'hFFFFFFFC, 1'b0, 32'd0,        1'b1, 1'b0, '0,       1'b0);
    add_row(MOOD_FAILING, 32'hFFFFFFFC, 1'b0, 32'd287,      1'b1, 1'b0, '0,       1'b0);
    add_row(MOOD_FAILING, 32'hFFFFFFFC, 1'b0, 32'd288,      1'b1, 1'b0, '0,       1'b0);
    add_row(MOOD_FAILING, 32'hFFFFFFFC, 1'b0, 32'hFFFFFFFF, 1'b1, 1'b0, '0,       1'b0);
    add_row(MOOD_FAILING, 32'd0,        1'b0, 32'd40,       1'b0, 1'b1, '0,       1'b0);
  endtask

  // register writes, only with the pipe empty
  task automatic apply_settings(input logic [2:0] m, input logic [31:0] s, input logic b,
                                input logic noisy);
    if (!noisy && m == cur_mood && s == cur_seed && b == cur_batt) return;
    in_tvalid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    // noisy writes put junk in the bits above each register
    cfg_wen   <= 1'b1;
    cfg_addr  <= CFG_MOOD;
    cfg_wdata <= noisy ? (($urandom & ~32'h7) | 32'(m)) : 32'(m);
    @(posedge clk);
    cfg_addr  <= CFG_SEED;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_addr  <= CFG_BATTERY;
    cfg_wdata <= noisy ? (($urandom & ~32'h1) | 32'(b)) : 32'(b);
    @(posedge clk);
    if (noisy) begin
      // write to the unused index must change nothing
      cfg_addr  <= CFG_UNUSED;
      cfg_wdata <= $urandom;
      @(posedge clk);
    end
    cfg_wen  <= 1'b0;
    cur_mood = m;
    cur_seed = s;
    cur_batt = b;
    n_settings++;
  endtask

  // one request; the expected result is queued at its acceptance edge
  task automatic push_request(input logic [31:0] t, input logic p, input logic typed,
                              input logic [16:0] lvl, input logic lit);
    lamp_out_t e;
    if (idle_on && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, p, t};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (typed) begin
      e.level = lvl;
      e.lit   = lit;
    end else begin
      e.level = lamp_level(cur_mood, cur_seed, cur_batt, t, p);
      e.lit   = e.level > LVL_VISIBLE;
    end
    level_q = {level_q, e};
    n_req++;
    if (cur_mood == MOOD_FLICKER && e.lit && e.level < FLK_STEADY_BASE) n_dips++;
    if (cur_mood == MOOD_FAILING && e.level != 0) n_lit_bursts++;
  endtask

  // request times steered toward the interesting parts of each mood
  function automatic logic [31:0] pick_time();
    logic [31:0] slot;
    logic [31:0] tstep;
    int          tries;
    case (cur_mood)
      MOOD_FAILING: begin
        if ($urandom_range(0, 9) < 7) begin
          // look for a slot that is not dark, then land near its start
          slot = $urandom_range(0, SLOT_MAX);
          for (tries = 0; tries < 32 && hash_frac(cur_seed + SEED_OFS_DARK, slot) < FAIL_DARK_TH;
               tries++)
            slot = $urandom_range(0, SLOT_MAX);
          return slot * FAIL_SLOT_TICKS +
                 (($urandom_range(0, 3) != 0) ? $urandom_range(0, 150) : $urandom_range(0, 287));
        end
      end
      MOOD_FLICKER: begin
        if ($urandom_range(0, 1) == 0) begin
          // look for a step that dips
          tstep = $urandom_range(0, FSTEP_MAX);
          for (tries = 0; tries < 64 && hash_frac(cur_seed, tstep) >= FLK_DIP_TH; tries++)
            tstep = $urandom_range(0, FSTEP_MAX);
          return tstep * FLK_STEP_TICKS + $urandom_range(0, 5);
        end
      end
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0) return ($urandom_range(0, 1) != 0) ? 32'hFFFFFFFF : 32'h0;
    return $urandom;
  endfunction

  function automatic logic [2:0] pick_mood();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r <= 2) return MOOD_FLICKER;
    if (r <= 5) return MOOD_FAILING;
    if (r <= 7) return MOOD_PULSE;
    if (r == 8) return 3'($urandom_range(0, 7));
    return ($urandom_range(0, 1) != 0) ? MOOD_DEAD : MOOD_STEADY;
  endfunction

  function automatic logic [31:0] pick_seed();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFFFFFF;
      2: return 32'hFFFFFFF8 | 32'($urandom_range(0, 7));  // offsets wrap
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned ph;
    int unsigned k;
    build_plan();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (plan_q[i]) begin
      apply_settings(plan_q[i].mood, plan_q[i].seed, plan_q[i].batt, 1'b0);
      push_request(plan_q[i].t_ticks, plan_q[i].pwr, plan_q[i].typed,
                   plan_q[i].level, plan_q[i].lit);
    end

    // random phases, the last ones without any idling
    for (ph = 0; ph < PHASES; ph++) begin
      idle_on = (ph < PHASES - CALM_PHASES);
      gap_pct = $urandom_range(0, 40);
      apply_settings(pick_mood(), pick_seed(), 1'($urandom_range(0, 1)), 1'b1);
      for (k = 0; k < PHASE_ITEMS; k++)
        push_request(pick_time(), 1'($urandom_range(0, 9) != 0), 1'b0, '0, 1'b0);
    end
    in_tvalid <= 1'b0;

    // drain, then watch a while for stray results
    while (level_q.size() != 0) @(posedge clk);
    repeat (NUM_STAGES + 8) @(posedge clk);

    $display("tb_top: %0d requests over %0d register settings, %0d results checked",
             n_req, n_settings, n_checked);
    $display("tb_top: %0d flicker dips, %0d lit failing steps, %0d mismatches",
             n_dips, n_lit_bursts, n_errors);
    if (n_errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // result side back-pressure in random bursts
  initial begin
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    lamp_out_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (level_q.size() == 0) begin
        n_errors++;
        $display("%0t: result with nothing expected, got brightness %0d visible %0d",
                 $time, out_tdata[16:0], out_tdata[17]);
      end else begin
        e = level_q.pop_front();
        n_checked++;
        if (out_tdata[16:0] !== e.level) begin
          n_errors++;
          $display("%0t: brightness expected %0d got %0d", $time, e.level, out_tdata[16:0]);
        end
        if (out_tdata[17] !== e.lit) begin
          n_errors++;
          $display("%0t: visible expected %0d got %0d", $time, e.lit, out_tdata[17]);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_top: no handshake for %0d cycles, %0d results outstanding",
                 quiet_cycles, level_q.size());
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

endmodule

/* sim.f */
hdl/hlf_pkg.sv
hdl/hlf_tdiv.sv
hdl/hlf_mix.sv
hdl/hlf_wave.sv
hdl/hashed_light_flicker_level.sv
tb/sv/tb_top.sv
